/* rtl/resource_string_unescaper_macros.svh */
// Assertion macros shared by the resource string unescaper RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef RESOURCE_STRING_UNESCAPER_MACROS_SVH
`define RESOURCE_STRING_UNESCAPER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define RSU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define RSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rsu_pkg.sv */
// Shared types and constants of the resource string unescaper.
// No dependencies; imported by every module of the block.
`default_nettype none

package rsu_pkg;

    localparam int UNIT_W = 16;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_BAD_HEX = 2'd1,
        STS_APOS    = 2'd2
    } status_t;

    localparam logic [UNIT_W-1:0] CH_TAB    = 16'h0009;
    localparam logic [UNIT_W-1:0] CH_LF     = 16'h000A;
    localparam logic [UNIT_W-1:0] CH_CR     = 16'h000D;
    localparam logic [UNIT_W-1:0] CH_SPACE  = 16'h0020;
    localparam logic [UNIT_W-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [UNIT_W-1:0] CH_HASH   = 16'h0023;
    localparam logic [UNIT_W-1:0] CH_APOS   = 16'h0027;
    localparam logic [UNIT_W-1:0] CH_QMARK  = 16'h003F;
    localparam logic [UNIT_W-1:0] CH_AT     = 16'h0040;
    localparam logic [UNIT_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] CH_LOW_N  = 16'h006E;
    localparam logic [UNIT_W-1:0] CH_LOW_T  = 16'h0074;
    localparam logic [UNIT_W-1:0] CH_LOW_U  = 16'h0075;

    // Work for the back end: an optional collapsed space, then an optional unit.
    typedef struct packed {
        logic              space;
        logic              unit_vld;
        logic [UNIT_W-1:0] unit;
        status_t           status;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/resource_string_unescaper.sv */
// Resource string unescaper, top level: front end, command queue, back end.
// Depends on rsu_pkg, rsu_front, rsu_queue, rsu_back and the macros header.
// An accepted unit is first written into the command queue, then loaded from the queue
// head into the output register, which drives the result.
// Throughput: one unit per cycle while the command queue is not full; a unit giving a space
// plus a unit makes the back end emit two results, absorbed by the QUEUE_DEPTH-entry command queue.
// Reset: synchronous, active low, clears all control state at once; no clearing pass.
`default_nettype none
`include "resource_string_unescaper_macros.svh"

module resource_string_unescaper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  wire logic        s_axis_tlast,   // end_of_piece
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] out_unit, [17:16] status, zero pad
    output logic             m_axis_tlast    // last result of the input transaction
);
    import rsu_pkg::*;

    logic    q_push, q_pop, q_full, q_empty;
    cmd_t    push_cmd, head_cmd;
    logic [15:0] res_unit;
    status_t res_status;

    // Classify each input transaction and queue the work it causes.
    rsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_unit  (s_axis_tdata),
        .in_eop   (s_axis_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Decouple the two sides so a stalled output does not hold the input.
    rsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (head_cmd),
        .empty   (q_empty)
    );

    // Expand each command into one or two output transactions.
    rsu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_cmd      (head_cmd),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_unit   (res_unit),
        .out_status (res_status),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, res_status, res_unit};

    // An error result stands alone and carries a zero unit.
    `RSU_ASSERT_NOW(a_err_is_last, aclk, aresetn,
        m_axis_tvalid && (res_status != STS_OK), m_axis_tlast,
        "error result not marked last")
    `RSU_ASSERT_NOW(a_err_zero_unit, aclk, aresetn,
        m_axis_tvalid && (res_status != STS_OK), res_unit == 16'h0000,
        "error result carries a nonzero unit")
    // Work enters the queue only for an accepted input and never past full.
    `RSU_ASSERT_NOW(a_push_on_accept, aclk, aresetn,
        q_push, s_axis_tvalid && s_axis_tready && !q_full,
        "command pushed without an accepted input")
    // Once an error is reported nothing else may follow it.
    `RSU_ASSERT_NEXT(a_no_result_after_err, aclk, aresetn,
        m_axis_tvalid && m_axis_tready && (res_status != STS_OK), !q_push && q_empty,
        "work queued after an error result")

endmodule

`default_nettype wire

/* rtl/rsu_front.sv */
// Front end: accepts code units, tracks escape/quote/space state, emits commands.
// Depends on rsu_pkg.
`default_nettype none

module rsu_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [15:0]  in_unit,
    input  wire logic         in_eop,
    input  wire logic         q_full,
    output logic              q_push,
    output rsu_pkg::cmd_t     q_cmd
);
    import rsu_pkg::*;

    logic              esc_reg, esc_next;
    logic              inq_reg, inq_next;
    logic              sp_reg, sp_next;
    logic              nonempty_reg, nonempty_next;
    logic [2:0]        hex_cnt_reg, hex_cnt_next;
    logic [UNIT_W-1:0] hex_val_reg, hex_val_next;
    logic              err_reg, err_next;

    logic              accept;
    logic              is_hex;
    logic [3:0]        hex_digit;
    logic [UNIT_W-1:0] hex_shift;
    logic              is_ws;
    cmd_t              cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        is_hex    = 1'b1;
        hex_digit = 4'd0;
        if (in_unit >= 16'h0030 && in_unit <= 16'h0039) begin
            hex_digit = in_unit[3:0];
        end else if ((in_unit >= 16'h0061 && in_unit <= 16'h0066) ||
                     (in_unit >= 16'h0041 && in_unit <= 16'h0046)) begin
            hex_digit = in_unit[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign hex_shift = {hex_val_reg[UNIT_W-5:0], hex_digit};
    assign is_ws     = (in_unit == CH_SPACE) || (in_unit >= CH_TAB && in_unit <= CH_CR);

    always_comb begin
        esc_next     = esc_reg;
        inq_next     = inq_reg;
        sp_next      = sp_reg;
        hex_cnt_next = hex_cnt_reg;
        hex_val_next = hex_val_reg;
        err_next     = err_reg;
        cmd          = '{space: 1'b0, unit_vld: 1'b0, unit: '0, status: STS_OK};

        if (!err_reg) begin
            if (hex_cnt_reg != 3'd0) begin
                if (!is_hex) begin
                    cmd.unit_vld = 1'b1;
                    cmd.status   = STS_BAD_HEX;
                    err_next     = 1'b1;
                end else if (hex_cnt_reg >= 3'd4) begin
                    cmd.unit_vld = 1'b1;
                    cmd.unit     = hex_shift;
                    hex_cnt_next = 3'd0;
                    hex_val_next = '0;
                end else if (in_eop) begin
                    hex_val_next = hex_shift;
                    cmd.unit_vld = 1'b1;
                    cmd.status   = STS_BAD_HEX;
                    err_next     = 1'b1;
                end else begin
                    hex_val_next = hex_shift;
                    hex_cnt_next = hex_cnt_reg + 3'd1;
                end
            end else if (esc_reg) begin
                esc_next = 1'b0;
                case (in_unit)
                    CH_LOW_T: begin
                        cmd.unit_vld = 1'b1;
                        cmd.unit     = CH_TAB;
                    end
                    CH_LOW_N: begin
                        cmd.unit_vld = 1'b1;
                        cmd.unit     = CH_LF;
                    end
                    CH_HASH, CH_AT, CH_QMARK, CH_DQUOTE, CH_APOS, CH_BSLASH: begin
                        cmd.unit_vld = 1'b1;
                        cmd.unit     = in_unit;
                    end
                    CH_LOW_U: begin
                        if (in_eop) begin
                            cmd.unit_vld = 1'b1;
                            cmd.status   = STS_BAD_HEX;
                            err_next     = 1'b1;
                        end else begin
                            hex_cnt_next = 3'd1;
                            hex_val_next = '0;
                        end
                    end
                    default: begin
                        // drop unknown escape
                    end
                endcase
            end else if (in_unit == CH_DQUOTE) begin
                if (!inq_reg && sp_reg) begin
                    cmd.space = nonempty_reg;
                    sp_next   = 1'b0;
                end
                inq_next = !inq_reg;
            end else if (in_unit == CH_APOS && !inq_reg) begin
                cmd.unit_vld = 1'b1;
                cmd.status   = STS_APOS;
                err_next     = 1'b1;
            end else if (in_unit == CH_BSLASH) begin
                if (!inq_reg && sp_reg) begin
                    cmd.space = nonempty_reg;
                    sp_next   = 1'b0;
                end
                esc_next = 1'b1;
            end else if (inq_reg) begin
                cmd.unit_vld = 1'b1;
                cmd.unit     = in_unit;
            end else if (is_ws) begin
                sp_next = 1'b1;
            end else begin
                if (sp_reg) begin
                    cmd.space = nonempty_reg;
                    sp_next   = 1'b0;
                end
                cmd.unit_vld = 1'b1;
                cmd.unit     = in_unit;
            end
        end

        nonempty_next = nonempty_reg || cmd.space ||
                        (cmd.unit_vld && cmd.status == STS_OK);
    end

    assign q_push = accept && (cmd.space || cmd.unit_vld);
    assign q_cmd  = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg      <= 1'b0;
            inq_reg      <= 1'b0;
            sp_reg       <= 1'b0;
            nonempty_reg <= 1'b0;
            hex_cnt_reg  <= 3'd0;
            hex_val_reg  <= '0;
            err_reg      <= 1'b0;
        end else if (accept) begin
            esc_reg      <= esc_next;
            inq_reg      <= inq_next;
            sp_reg       <= sp_next;
            nonempty_reg <= nonempty_next;
            hex_cnt_reg  <= hex_cnt_next;
            hex_val_reg  <= hex_val_next;
            err_reg      <= err_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/rsu_queue.sv */
// Small command queue between front and back end, built from flip-flops.
// Depends on rsu_pkg.
`default_nettype none

module rsu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire rsu_pkg::cmd_t wdata,
    output logic               full,
    input  wire logic          pop,
    output rsu_pkg::cmd_t      rdata,
    output logic               empty
);
    import rsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

`default_nettype wire

/* rtl/rsu_back.sv */
// Back end: expands queued commands into results and drives the output register.
// Depends on rsu_pkg.
`default_nettype none

module rsu_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_empty,
    input  wire rsu_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [15:0]        out_unit,
    output rsu_pkg::status_t   out_status,
    output logic               out_last
);
    import rsu_pkg::*;

    logic              vld_reg, vld_next;
    logic              phase_reg, phase_next;
    logic [UNIT_W-1:0] unit_reg, unit_next;
    status_t           sts_reg, sts_next;
    logic              last_reg, last_next;
    logic              load;

    assign load = !vld_reg || out_ready;

    always_comb begin
        vld_next   = vld_reg && !out_ready;
        phase_next = phase_reg;
        unit_next  = unit_reg;
        sts_next   = sts_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (load && !q_empty) begin
            vld_next = 1'b1;
            if (q_cmd.space && !phase_reg) begin
                unit_next = CH_SPACE;
                sts_next  = STS_OK;
                last_next = !q_cmd.unit_vld;
                if (q_cmd.unit_vld) begin
                    phase_next = 1'b1;
                end else begin
                    q_pop = 1'b1;
                end
            end else begin
                unit_next  = q_cmd.unit;
                sts_next   = q_cmd.status;
                last_next  = 1'b1;
                phase_next = 1'b0;
                q_pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            vld_reg   <= vld_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        unit_reg <= unit_next;
        sts_reg  <= sts_next;
        last_reg <= last_next;
    end

    assign out_valid  = vld_reg;
    assign out_unit   = unit_reg;
    assign out_status = sts_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire
